// ----- hw/rtl/sssd_pkg.sv -----
// Shared types, constants and font table for the seven-segment scan driver.
// No dependencies.
package sssd_pkg;

    localparam int DIGITS    = 4;
    localparam int POS_W     = 2;
    localparam int CODE_W    = 7;
    localparam int NUM_W     = 16;
    localparam int BCD_W     = 14;
    localparam int FONT_SIZE = 96;

    localparam logic [NUM_W-1:0]  NUM_LIMIT  = 16'd9999;
    localparam logic [7:0]        DOT_BIT    = 8'h80;
    localparam logic [CODE_W-1:0] BLANK_CODE = 7'd10;
    localparam logic [POS_W-1:0]  DOT_DIGIT  = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_NUMBER = 2'd1,
        OP_CHAR   = 2'd2,
        OP_RUN    = 2'd3
    } t_op;

    typedef logic [CODE_W-1:0] t_code;

    // Control part of an item as it moves down the pipe.
    typedef struct packed {
        t_op              op;
        logic [POS_W-1:0] position;
        t_code            char_code;
        logic             run_flag;
    } t_item;

    // One memory row: the whole display state.
    typedef struct packed {
        logic              dot;
        logic [POS_W-1:0]  pos;
        t_code [DIGITS-1:0] codes;
    } t_row;

    localparam int ROW_W = $bits(t_row);

    // "STOP": digit 0 holds 29, digit 3 holds 26.
    localparam t_row ROW_RESET = '{
        dot:   1'b0,
        pos:   '0,
        codes: {7'd26, 7'd25, 7'd30, 7'd29}
    };

    localparam logic [7:0] FONT [FONT_SIZE] = '{
        8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B,
        8'h00,
        8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'h47, 8'h3D, 8'h76, 8'h30, 8'h1E,
        8'h75, 8'h38, 8'h15, 8'h37, 8'h7E, 8'h67, 8'h6B, 8'h33, 8'h5B, 8'h46,
        8'h3E, 8'h3E, 8'h2A, 8'h76, 8'h6E, 8'h5B,
        8'h09, 8'h0D, 8'h61, 8'h48, 8'h43, 8'hD3, 8'h5F,
        8'h39, 8'h64, 8'h0F, 8'h23, 8'h08, 8'h02,
        8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h71, 8'h6F, 8'h74, 8'h10, 8'h0C,
        8'h75, 8'h30, 8'h14, 8'h54, 8'h5C, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78,
        8'h1C, 8'h1C, 8'h14, 8'h76, 8'h6E, 8'h5B,
        8'h46, 8'h30, 8'h70, 8'h01, 8'h00,
        8'h86, 8'h22, 8'h7E, 8'h6D, 8'hD2, 8'h46, 8'h20, 8'h29, 8'h0B, 8'h21,
        8'h70, 8'h10, 8'h40, 8'h80, 8'h52
    };

    // Codes past the font show blank.
    function automatic logic [7:0] glyph_of(input t_code code);
        logic [7:0] pat;
        pat = 8'h00;
        if (code < CODE_W'(FONT_SIZE)) begin
            pat = FONT[code];
        end
        return pat;
    endfunction

endpackage

// ----- hw/rtl/seven_segment_scan_driver.sv -----
// Top level of the four-digit multiplexed seven-segment scan driver.
// Depends on sssd_pkg and sssd_ram.
//
// Usage:
//  - Slave channel (i_s_*) takes one beat per cycle while ready. tuser is the
//    opcode: scan tick, number write, character write or run-flag write.
//  - Master channel (o_m_*) returns exactly one beat per command: the held
//    digit enable and segment pattern after that command. Only a scan tick
//    changes them; other commands repeat the last values.
//  - Pipeline: an accepted beat is registered, split into decimal digits
//    by the divide stages, then updates the state into the output register.
//  - Throughput: one command per cycle unless stalled, limited by the single
//    read-modify-write of the display row each cycle; a row write in one
//    cycle is forwarded to the next; back-to-back commands need no bubbles.
//  - Reset: pipe and output empty, display row reads "STOP", scan at digit
//    0, run flag clear, no digit lit and all segments dark.
//  - Stall: when i_m_tready is low the result holds; upstream stages keep
//    filling their empty slots and o_s_tready drops only when every stage
//    is occupied.
module seven_segment_scan_driver
    import sssd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [15:0] number_value, [17:16] position, [24:18] char_code, [25] run_flag
    input  logic [31:0] i_s_tdata,
    // [1:0] opcode
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [3:0] digit_enable, [11:4] segments
    output logic [15:0] o_m_tdata
);

    // Handshake chain
    logic r_v1, r_v2, r_v3, r_v4, r_ov;
    logic out_rdy, rdy4, rdy3, rdy2, rdy1;
    logic s_acc, we;

    assign out_rdy    = !r_ov || i_m_tready;
    assign rdy4       = !r_v4 || out_rdy;
    assign rdy3       = !r_v3 || rdy4;
    assign rdy2       = !r_v2 || rdy3;
    assign rdy1       = !r_v1 || rdy2;
    assign o_s_tready = rdy1;
    assign s_acc      = i_s_tvalid && rdy1;
    assign we         = r_v4 && out_rdy;

    // Stage payloads
    t_item            r1_item, r2_item, r3_item, r4_item;
    logic [BCD_W-1:0] r1_n, r2_n;
    logic [6:0]       r2_q100;
    logic [3:0]       r3_h;
    logic [6:0]       r3_r100;
    t_code            r4_hcode, r4_tcode, r4_ucode;

    // Stage 1 input: unpack, with numbers above 9999 read as zero
    t_item            in_item;
    logic [NUM_W-1:0] in_num;
    logic [BCD_W-1:0] in_n;

    always_comb begin
        in_num             = i_s_tdata[15:0];
        in_item.op         = t_op'(i_s_tuser);
        in_item.position   = i_s_tdata[17:16];
        in_item.char_code  = i_s_tdata[24:18];
        in_item.run_flag   = i_s_tdata[25];
        in_n               = (in_num > NUM_LIMIT) ? '0 : in_num[BCD_W-1:0];
    end

    // Stage 1 -> 2: n / 100 by reciprocal, exact below 10000
    logic [26:0] q100_prod;
    assign q100_prod = 27'(r1_n) * 27'd5243;

    // Stage 2 -> 3: n % 100 and hundreds = (n / 100) % 10
    logic [15:0] q10_prod;
    logic [3:0]  q10;
    logic [BCD_W-1:0] r100_full;
    logic [6:0]  h_full;

    always_comb begin
        q10_prod  = 16'(r2_q100) * 16'd205;
        q10       = q10_prod[14:11];
        r100_full = r2_n - (BCD_W'(r2_q100) * BCD_W'(100));
        h_full    = r2_q100 - (7'(q10) * 7'd10);
    end

    // Stage 3 -> 4: tens and units of n % 100
    logic [15:0] t_prod;
    logic [3:0]  tens;
    logic [6:0]  units;

    always_comb begin
        t_prod = 16'(r3_r100) * 16'd205;
        tens   = t_prod[14:11];
        units  = r3_r100 - (7'(tens) * 7'd10);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_s_tvalid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
            if (out_rdy) begin
                r_ov <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r1_item <= in_item;
            r1_n    <= in_n;
        end
        if (rdy2 && r_v1) begin
            r2_item <= r1_item;
            r2_n    <= r1_n;
            r2_q100 <= q100_prod[25:19];
        end
        if (rdy3 && r_v2) begin
            r3_item <= r2_item;
            r3_h    <= h_full[3:0];
            r3_r100 <= r100_full[6:0];
        end
        if (rdy4 && r_v3) begin
            r4_item  <= r3_item;
            r4_hcode <= (r3_h == 4'd0) ? BLANK_CODE : t_code'(r3_h);
            r4_tcode <= t_code'(tens);
            r4_ucode <= t_code'(units);
        end
    end

    // Display row memory with forwarding of last cycle's write
    logic [ROW_W-1:0] ram_rdata;
    logic             r_row_vld;
    logic             r_wr_d;
    t_row             r_fwd;
    t_row             row_cur, row_nx;

    sssd_ram #(
        .WIDTH (ROW_W),
        .DEPTH (1)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr ('0),
        .i_wdata (row_nx),
        .i_raddr ('0),
        .o_rdata (ram_rdata)
    );

    // Row reads as reset value until first written
    always_comb begin
        priority if (!r_row_vld) begin
            row_cur = ROW_RESET;
        end else if (r_wr_d) begin
            row_cur = r_fwd;
        end else begin
            row_cur = t_row'(ram_rdata);
        end
    end

    // Held display outputs
    logic [DIGITS-1:0] r_en, n_en;
    logic [7:0]        r_seg, n_seg;
    logic [7:0]        pat;

    always_comb begin
        row_nx = row_cur;
        n_en   = r_en;
        n_seg  = r_seg;
        pat    = glyph_of(row_cur.codes[row_cur.pos]);
        unique case (r4_item.op)
            OP_TICK: begin
                if (row_cur.pos == DOT_DIGIT && row_cur.dot) begin
                    pat = pat | DOT_BIT;
                end
                n_en       = DIGITS'(1) << row_cur.pos;
                n_seg      = pat;
                row_nx.pos = row_cur.pos + POS_W'(1);
            end
            OP_NUMBER: begin
                row_nx.codes[1] = r4_hcode;
                row_nx.codes[2] = r4_tcode;
                row_nx.codes[3] = r4_ucode;
            end
            OP_CHAR: begin
                row_nx.codes[r4_item.position] = r4_item.char_code;
            end
            OP_RUN: begin
                row_nx.dot = r4_item.run_flag;
            end
            default: begin
                row_nx = row_cur;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= 1'b0;
            r_wr_d    <= 1'b0;
            r_en      <= '0;
            r_seg     <= '0;
        end else begin
            r_wr_d <= we;
            if (we) begin
                r_row_vld <= 1'b1;
                r_en      <= n_en;
                r_seg     <= n_seg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_fwd <= row_nx;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {4'b0000, r_seg, r_en};

endmodule

// ----- hw/rtl/sssd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sssd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the contents before a same-cycle write.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- dv/tb_display_pkg.sv -----
// Scoreboard for the seven-segment scan driver testbench: display-state
// predictor and the queue of expected enable/segment beats.
// Depends on sssd_pkg for the opcode enum and display constants.
package tb_display_pkg;
    import sssd_pkg::*;

    typedef struct packed {
        logic [3:0] enable;
        logic [7:0] segments;
    } t_lit;

    // Segment patterns by character code, bit7 DP, bit6 A .. bit0 G.
    localparam logic [7:0] GLYPH_ROM [96] = '{
        8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B,
        8'h00,
        8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'h47, 8'h3D, 8'h76, 8'h30, 8'h1E,
        8'h75, 8'h38, 8'h15, 8'h37, 8'h7E, 8'h67, 8'h6B, 8'h33, 8'h5B, 8'h46,
        8'h3E, 8'h3E, 8'h2A, 8'h76, 8'h6E, 8'h5B,
        8'h09, 8'h0D, 8'h61, 8'h48, 8'h43, 8'hD3, 8'h5F,
        8'h39, 8'h64, 8'h0F, 8'h23, 8'h08, 8'h02,
        8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h71, 8'h6F, 8'h74, 8'h10, 8'h0C,
        8'h75, 8'h30, 8'h14, 8'h54, 8'h5C, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78,
        8'h1C, 8'h1C, 8'h14, 8'h76, 8'h6E, 8'h5B,
        8'h46, 8'h30, 8'h70, 8'h01, 8'h00,
        8'h86, 8'h22, 8'h7E, 8'h6D, 8'hD2, 8'h46, 8'h20, 8'h29, 8'h0B, 8'h21,
        8'h70, 8'h10, 8'h40, 8'h80, 8'h52
    };

    class display_tracker;
        t_code      codes [DIGITS];
        logic [1:0] scan_pos;
        logic       dot;
        t_lit       held;
        t_lit       pending_lit [$];
        int         mismatches;

        function new();
            // Power-up text "STOP".
            codes[0]   = 7'd29;
            codes[1]   = 7'd30;
            codes[2]   = 7'd25;
            codes[3]   = 7'd26;
            scan_pos   = '0;
            dot        = 1'b0;
            held       = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return pending_lit.size();
        endfunction

        // Update the display state for one accepted command beat and queue
        // the held outputs that follow it.
        function void note_command(t_op op, logic [15:0] number, logic [1:0] pos,
                                   t_code code, logic flag);
            int         n;
            int         hundreds;
            logic [7:0] pat;
            case (op)
                OP_TICK: begin
                    pat = (codes[scan_pos] < FONT_SIZE) ? GLYPH_ROM[codes[scan_pos]] : 8'h00;
                    if (scan_pos == DOT_DIGIT && dot) begin
                        pat = pat | DOT_BIT;
                    end
                    held.enable   = 4'b0001 << scan_pos;
                    held.segments = pat;
                    scan_pos      = scan_pos + 2'd1;
                end
                OP_NUMBER: begin
                    n        = (number > NUM_LIMIT) ? 0 : int'(number);
                    hundreds = (n % 1000) / 100;
                    codes[1] = (hundreds == 0) ? BLANK_CODE : t_code'(hundreds);
                    codes[2] = t_code'((n % 100) / 10);
                    codes[3] = t_code'(n % 10);
                end
                OP_CHAR: begin
                    codes[pos] = code;
                end
                default: begin
                    dot = flag;
                end
            endcase
            pending_lit.push_back(held);
        endfunction

        // Compare one accepted result beat with the oldest expectation.
        function void check_beat(logic [15:0] tdata);
            t_lit want;
            if (pending_lit.size() == 0) begin
                $error("unexpected result beat: digit_enable %h segments %h",
                       tdata[3:0], tdata[11:4]);
                mismatches++;
            end else begin
                want = pending_lit.pop_front();
                if (tdata[3:0] !== want.enable) begin
                    $error("digit_enable: expected %h, actual %h", want.enable, tdata[3:0]);
                    mismatches++;
                end
                if (tdata[11:4] !== want.segments) begin
                    $error("segments: expected %h, actual %h", want.segments, tdata[11:4]);
                    mismatches++;
                end
            end
        endfunction
    endclass

endpackage

// ----- dv/tb_top.sv -----
// Testbench top for the seven-segment scan driver: directed and random
// command beats with random idling on both stream sides, checked per beat.
// Depends on sssd_pkg, tb_display_pkg and seven_segment_scan_driver.
module tb_top;
    import sssd_pkg::*;
    import tb_display_pkg::*;

    localparam int RANDOM_CMDS = 1850;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 20;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [31:0] i_s_tdata  = '0;
    logic [1:0]  i_s_tuser  = '0;
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [15:0] o_m_tdata;

    bit src_idling  = 1'b1;
    bit sink_idling = 1'b1;
    int cycle_count = 0;

    display_tracker tracker;

    seven_segment_scan_driver dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sink back-pressure, about 28 stalls in a hundred while enabled.
    always @(posedge i_clk) begin
        i_m_tready <= !sink_idling || ($urandom_range(99) >= 28);
    end

    // Beat monitor: values read here are the ones present before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                tracker.note_command(t_op'(i_s_tuser), i_s_tdata[15:0], i_s_tdata[17:16],
                                     i_s_tdata[24:18], i_s_tdata[25]);
            end
            if (o_m_tvalid && i_m_tready) begin
                tracker.check_beat(o_m_tdata);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("seven_segment_scan_driver: mismatch");
        $finish;
    end

    // Present one command beat, with optional random gaps first; returns at
    // the edge where it is taken.
    task automatic send_cmd(input t_op op, input logic [15:0] number,
                            input logic [1:0] pos, input t_code code, input logic flag);
        while (src_idling && $urandom_range(99) < 28) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= $urandom;
            i_s_tuser  <= 2'($urandom);
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {6'b0, flag, code, pos, number};
        // Ready is settled by the falling edge; the beat goes at the next rise.
        @(negedge i_clk);
        while (!o_s_tready) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    // Stop sending and wait for every queued result to come back.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_random_cmd();
        int          pick;
        t_op         op;
        logic [15:0] number;
        t_code       code;
        pick = $urandom_range(99);
        if (pick < 50) begin
            op = OP_TICK;
        end else if (pick < 70) begin
            op = OP_NUMBER;
        end else if (pick < 90) begin
            op = OP_CHAR;
        end else begin
            op = OP_RUN;
        end
        // Mostly displayable numbers, some around the overflow edge.
        pick = $urandom_range(99);
        if (pick < 60) begin
            number = 16'($urandom_range(9999));
        end else if (pick < 70) begin
            number = 16'($urandom_range(10010, 9990));
        end else begin
            number = 16'($urandom_range(65535));
        end
        code = ($urandom_range(99) < 80) ? t_code'($urandom_range(95))
                                         : t_code'($urandom_range(127, 96));
        send_cmd(op, number, 2'($urandom), code, 1'($urandom));
    endtask

    initial begin
        tracker = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Outputs before any tick, then one scan of the power-up text.
        send_cmd(OP_RUN, 16'h0000, 2'd0, 7'd0, 1'b0);
        repeat (4) send_cmd(OP_TICK, 16'hFFFF, 2'd3, 7'd127, 1'b1);
        // Overflowing number clears to blank hundreds; top font entry on digit 0.
        send_cmd(OP_RUN, 16'hFFFF, 2'd3, 7'd127, 1'b1);
        send_cmd(OP_NUMBER, 16'd10000, 2'd0, 7'd0, 1'b0);
        send_cmd(OP_CHAR, 16'd0, 2'd0, 7'd95, 1'b0);
        repeat (4) send_cmd(OP_TICK, 16'd0, 2'd0, 7'd0, 1'b0);
        // Dot over a glyph that already has DP, codes past the font.
        send_cmd(OP_CHAR, 16'd0, 2'd2, 7'd42, 1'b0);
        send_cmd(OP_CHAR, 16'd0, 2'd1, 7'd127, 1'b0);
        send_cmd(OP_CHAR, 16'd0, 2'd3, 7'd96, 1'b0);
        repeat (4) send_cmd(OP_TICK, 16'd0, 2'd0, 7'd0, 1'b0);
        send_cmd(OP_NUMBER, 16'd9999, 2'd0, 7'd0, 1'b0);
        send_cmd(OP_NUMBER, 16'd65535, 2'd0, 7'd0, 1'b0);
        send_cmd(OP_NUMBER, 16'd1234, 2'd0, 7'd0, 1'b0);
        repeat (3) send_cmd(OP_TICK, 16'd0, 2'd0, 7'd0, 1'b0);
        send_cmd(OP_CHAR, 16'd0, 2'd0, 7'd10, 1'b0);
        drain();

        for (int i = 0; i < RANDOM_CMDS; i++) begin
            // Middle stretch runs both sides at full rate.
            src_idling  = !(i >= 600 && i < 1000);
            sink_idling = src_idling;
            if (i == 1200) begin
                drain();
            end
            send_random_cmd();
        end
        drain();
        repeat (SETTLE) @(posedge i_clk);

        if (tracker.mismatches == 0) begin
            $display("seven_segment_scan_driver: match");
        end else begin
            $display("seven_segment_scan_driver: mismatch");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/sssd_pkg.sv
hw/rtl/sssd_ram.sv
hw/rtl/seven_segment_scan_driver.sv
dv/tb_display_pkg.sv
dv/tb_top.sv
